// ===== hw/rtl/assert_macros.svh =====
// Assertion macros included by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== hw/rtl/sm83_pkg.sv =====
// Opcode, register-code and result definitions for the SM83 load/add core.
`default_nettype none

package sm83_pkg;

	// Control opcodes.
	localparam logic [7:0] OP_NOP  = 8'h00;
	localparam logic [7:0] OP_STOP = 8'h10;
	localparam logic [7:0] OP_HALT = 8'h76;
	localparam logic [7:0] OP_DI   = 8'hF3;
	localparam logic [7:0] OP_EI   = 8'hFB;

	// Opcode groups, selected by the top two bits.
	localparam logic [1:0] GRP_LD  = 2'b01;
	localparam logic [1:0] GRP_ALU = 2'b10;

	// ALU operation code within the ALU group.
	localparam logic [2:0] ALU_ADD = 3'd0;

	// Register operand codes as they sit in the opcode.
	localparam logic [2:0] CODE_B  = 3'd0;
	localparam logic [2:0] CODE_C  = 3'd1;
	localparam logic [2:0] CODE_D  = 3'd2;
	localparam logic [2:0] CODE_E  = 3'd3;
	localparam logic [2:0] CODE_H  = 3'd4;
	localparam logic [2:0] CODE_L  = 3'd5;
	localparam logic [2:0] CODE_HL = 3'd6;
	localparam logic [2:0] CODE_A  = 3'd7;

	// Cycle costs.
	localparam logic [3:0] CYC_SHORT = 4'd4;
	localparam logic [3:0] CYC_LONG  = 4'd8;

	// Flag bit positions.
	localparam int FLAG_Z = 3;
	localparam int FLAG_N = 2;
	localparam int FLAG_H = 1;
	localparam int FLAG_C = 0;

	// One result item, first field in the highest bits.
	typedef struct packed {
		logic [3:0]  clock_count;
		logic [15:0] pair_hl;
		logic        interrupts_enabled;
		logic [3:0]  flag_bits;
		logic [7:0]  accumulator;
		logic [7:0]  mem_write_data;
		logic [15:0] mem_write_address;
		logic        mem_write_enable;
	} result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sm83_load_add_execute.sv =====
// Top level of the SM83 load/add core: decode, execute and result register.
//
//  Channel  | Dir | tdata fields (low bit up)              | tuser
//  s_axis   | in  | func[7:0], mem_read_data[15:8]          | -
//  m_axis   | out | result_t, 58 bits packed, zero to 64   | unknown_opcode
//
// Each request is executed in the cycle it is accepted; its result is ready the next cycle.
// One request per cycle is sustained while the output is taken; the only limit is the single result register.
// The input is taken whenever the result register is empty or being drained.
// Reset clears A, B, C, D, E, H, L, the flags and the interrupt enable.
// A stall on the output holds the result and blocks new requests until it is taken.
`default_nettype none

`include "assert_macros.svh"

module sm83_load_add_execute
	import sm83_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [15:0] s_tdata,   // func[7:0], mem_read_data[15:8]
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [63:0] m_tdata,   // mem_write_enable[0], mem_write_address[16:1],
	                                    // mem_write_data[24:17], accumulator[32:25],
	                                    // flag_bits[36:33], interrupts_enabled[37],
	                                    // pair_hl[53:38], clock_count[57:54], zero above
	output      logic        m_tuser    // unknown_opcode[0]
);

	// Architectural state.
	logic [7:0] a_q, b_q, c_q, d_q, e_q, h_q, l_q;
	logic [3:0] flags_q;
	logic       ime_q;

	// Result register.
	logic       out_valid_q;
	result_t    res_q;
	logic       unknown_q;

	logic [7:0] func;
	logic [7:0] mem_read_data;
	logic       accept;

	// Decode and execute signals.
	logic [2:0] dst_code, src_code;
	logic [7:0] src_val;
	logic       is_nop, is_di, is_ei, is_ld, is_add, unknown;
	logic       mem_we;
	logic [8:0] sum;
	logic [4:0] half_sum;
	logic [7:0] a_n, b_n, c_n, d_n, e_n, h_n, l_n;
	logic [3:0] flags_n;
	logic       ime_n;
	result_t    res_n;

	assign func          = s_tdata[7:0];
	assign mem_read_data = s_tdata[15:8];
	assign s_tready      = !out_valid_q || m_tready;
	assign accept        = s_tvalid && s_tready;

	assign dst_code = func[5:3];
	assign src_code = func[2:0];

	// Opcode classification; HALT is matched before the load group.
	assign is_nop = (func == OP_NOP) || (func == OP_STOP) || (func == OP_HALT);
	assign is_di  = (func == OP_DI);
	assign is_ei  = (func == OP_EI);
	assign is_ld  = (func[7:6] == GRP_LD) && (func != OP_HALT);
	assign is_add = (func[7:6] == GRP_ALU) && (func[5:3] == ALU_ADD);
	assign unknown = !(is_nop || is_di || is_ei || is_ld || is_add);
	assign mem_we  = is_ld && (dst_code == CODE_HL);

	// Source operand select; the (HL) code takes the supplied memory byte.
	always_comb begin
		case (src_code)
			CODE_B:  src_val = b_q;
			CODE_C:  src_val = c_q;
			CODE_D:  src_val = d_q;
			CODE_E:  src_val = e_q;
			CODE_H:  src_val = h_q;
			CODE_L:  src_val = l_q;
			CODE_HL: src_val = mem_read_data;
			CODE_A:  src_val = a_q;
			default: src_val = a_q;
		endcase
	end

	// 8-bit add with the carry out of bit 3 computed separately.
	assign sum      = {1'b0, a_q} + {1'b0, src_val};
	assign half_sum = {1'b0, a_q[3:0]} + {1'b0, src_val[3:0]};

	// Next architectural state.
	always_comb begin
		a_n     = a_q;
		b_n     = b_q;
		c_n     = c_q;
		d_n     = d_q;
		e_n     = e_q;
		h_n     = h_q;
		l_n     = l_q;
		flags_n = flags_q;
		ime_n   = ime_q;
		if (is_di) begin
			ime_n = 1'b0;
		end
		if (is_ei) begin
			ime_n = 1'b1;
		end
		if (is_ld) begin
			case (dst_code)
				CODE_B:  b_n = src_val;
				CODE_C:  c_n = src_val;
				CODE_D:  d_n = src_val;
				CODE_E:  e_n = src_val;
				CODE_H:  h_n = src_val;
				CODE_L:  l_n = src_val;
				CODE_A:  a_n = src_val;
				default: ;
			endcase
		end
		if (is_add) begin
			a_n             = sum[7:0];
			flags_n[FLAG_Z] = (sum[7:0] == 8'h00);
			flags_n[FLAG_N] = 1'b0;
			flags_n[FLAG_H] = half_sum[4];
			flags_n[FLAG_C] = sum[8];
		end
	end

	// Result fields.
	always_comb begin
		res_n.mem_write_enable   = mem_we;
		res_n.mem_write_address  = mem_we ? {h_q, l_q} : 16'h0000;
		res_n.mem_write_data     = mem_we ? src_val : 8'h00;
		res_n.accumulator        = a_n;
		res_n.flag_bits          = flags_n;
		res_n.interrupts_enabled = ime_n;
		res_n.pair_hl            = {h_n, l_n};
		res_n.clock_count        = ((is_ld || is_add) &&
			((src_code == CODE_HL) || (dst_code == CODE_HL) && is_ld)) ? CYC_LONG : CYC_SHORT;
	end

	// State update on each accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q     <= 8'h00;
			b_q     <= 8'h00;
			c_q     <= 8'h00;
			d_q     <= 8'h00;
			e_q     <= 8'h00;
			h_q     <= 8'h00;
			l_q     <= 8'h00;
			flags_q <= 4'h0;
			ime_q   <= 1'b0;
		end else if (accept) begin
			a_q     <= a_n;
			b_q     <= b_n;
			c_q     <= c_n;
			d_q     <= d_n;
			e_q     <= e_n;
			h_q     <= h_n;
			l_q     <= l_n;
			flags_q <= flags_n;
			ime_q   <= ime_n;
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q     <= res_n;
			unknown_q <= unknown;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, res_q};
	assign m_tuser  = unknown_q;

	// An unknown opcode never writes memory.
	`SM_ASSERT_IMP(a_unknown_no_write, clk, arst_n,
		out_valid_q && unknown_q, !res_q.mem_write_enable)
	// A memory write always costs the long cycle count.
	`SM_ASSERT_IMP(a_write_long, clk, arst_n,
		out_valid_q && res_q.mem_write_enable, res_q.clock_count == CYC_LONG)
	// DI clears the interrupt enable for the following request.
	`SM_ASSERT_NXT(a_di_clears, clk, arst_n, accept && (func == OP_DI), !ime_q)
	// An unknown opcode leaves the flags untouched.
	`SM_ASSERT_NXT(a_unknown_keeps_flags, clk, arst_n,
		accept && unknown, flags_q == $past(flags_q))

endmodule

`default_nettype wire

// ===== tb/sv/sm83_load_add_checker.sv =====
// Checker for the SM83 load/add core: predicts every result and compares it on the output.
`timescale 1ns / 1ps

module sm83_load_add_checker
	import sm83_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [15:0] s_tdata,   // func[7:0], mem_read_data[15:8]
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [63:0] m_tdata,   // mem_write_enable[0], mem_write_address[16:1],
	                                    // mem_write_data[24:17], accumulator[32:25],
	                                    // flag_bits[36:33], interrupts_enabled[37],
	                                    // pair_hl[53:38], clock_count[57:54], zero above
	input  wire logic        m_tuser,   // unknown_opcode[0]
	output int               error_count,
	output int               pending_count,
	output int               results_checked
);

	// Positions of A, B, C, D, E, H and L in the register file.
	localparam int IDX_A = 0;
	localparam int IDX_B = 1;
	localparam int IDX_C = 2;
	localparam int IDX_D = 3;
	localparam int IDX_E = 4;
	localparam int IDX_H = 5;
	localparam int IDX_L = 6;

	// Only the first mismatches are printed; all of them are counted.
	localparam int MAX_REPORTS = 50;

	typedef struct packed {
		result_t body;
		logic    unknown;
	} cpu_outcome_t;

	// Architectural state as the core should hold it.
	logic [7:0] cpu_regs [7];
	logic [3:0] cpu_flags;
	logic       cpu_ime;

	cpu_outcome_t outcome_queue [$];
	cpu_outcome_t predicted;
	cpu_outcome_t oldest;
	result_t      observed;

	int errors = 0;
	int pending = 0;
	int checked = 0;

	assign error_count     = errors;
	assign pending_count   = pending;
	assign results_checked = checked;

	// Register operand code from the opcode to register file position.
	function automatic int reg_index(input logic [2:0] code);
		case (code)
			CODE_B:  reg_index = IDX_B;
			CODE_C:  reg_index = IDX_C;
			CODE_D:  reg_index = IDX_D;
			CODE_E:  reg_index = IDX_E;
			CODE_H:  reg_index = IDX_H;
			CODE_L:  reg_index = IDX_L;
			default: reg_index = IDX_A;
		endcase
	endfunction

	// Add a byte into A and rebuild all four flags.
	task automatic add_to_accumulator(input logic [7:0] value);
		logic [8:0] sum;
		logic [4:0] low_sum;
		begin
			sum     = {1'b0, cpu_regs[IDX_A]} + {1'b0, value};
			low_sum = {1'b0, cpu_regs[IDX_A][3:0]} + {1'b0, value[3:0]};
			cpu_flags         = '0;
			cpu_flags[FLAG_Z] = (sum[7:0] == 8'h00);
			cpu_flags[FLAG_H] = low_sum[4];
			cpu_flags[FLAG_C] = sum[8];
			cpu_regs[IDX_A]   = sum[7:0];
		end
	endtask

	// Execute one opcode on the shadow state and build the result it should produce.
	task automatic execute_opcode(input logic [7:0] func, input logic [7:0] mem_byte,
			output cpu_outcome_t outcome);
		logic [15:0] hl_before;
		logic [2:0]  dst;
		logic [2:0]  src;
		begin
			hl_before = {cpu_regs[IDX_H], cpu_regs[IDX_L]};
			dst       = func[5:3];
			src       = func[2:0];
			outcome   = '0;
			outcome.body.clock_count = CYC_SHORT;

			if (func == OP_NOP || func == OP_STOP || func == OP_HALT) begin
				// Nothing changes.
			end else if (func == OP_DI) begin
				cpu_ime = 1'b0;
			end else if (func == OP_EI) begin
				cpu_ime = 1'b1;
			end else if (func[7:6] == GRP_LD) begin
				if (dst == CODE_HL) begin
					outcome.body.mem_write_enable  = 1'b1;
					outcome.body.mem_write_address = hl_before;
					outcome.body.mem_write_data    = cpu_regs[reg_index(src)];
					outcome.body.clock_count       = CYC_LONG;
				end else if (src == CODE_HL) begin
					cpu_regs[reg_index(dst)] = mem_byte;
					outcome.body.clock_count = CYC_LONG;
				end else begin
					cpu_regs[reg_index(dst)] = cpu_regs[reg_index(src)];
				end
			end else if (func[7:6] == GRP_ALU && func[5:3] == ALU_ADD) begin
				if (src == CODE_HL) begin
					add_to_accumulator(mem_byte);
					outcome.body.clock_count = CYC_LONG;
				end else begin
					add_to_accumulator(cpu_regs[reg_index(src)]);
				end
			end else begin
				outcome.unknown = 1'b1;
			end

			outcome.body.accumulator        = cpu_regs[IDX_A];
			outcome.body.flag_bits          = cpu_flags;
			outcome.body.interrupts_enabled = cpu_ime;
			outcome.body.pair_hl            = {cpu_regs[IDX_H], cpu_regs[IDX_L]};
		end
	endtask

	task automatic compare_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		begin
			if (got !== want) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: %s expected %h, actual %h", $time, field, want, got);
			end
		end
	endtask

	// Retire results first, then queue the prediction for a request taken at the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 7; i++)
				cpu_regs[i] = 8'h00;
			cpu_flags = 4'h0;
			cpu_ime   = 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				observed = result_t'(m_tdata[57:0]);
				if (outcome_queue.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: result expected none pending, actual %h",
							$time, m_tdata);
				end else begin
					oldest = outcome_queue.pop_front();
					compare_field("mem_write_enable", 16'(oldest.body.mem_write_enable),
						16'(observed.mem_write_enable));
					compare_field("mem_write_address", oldest.body.mem_write_address,
						observed.mem_write_address);
					compare_field("mem_write_data", 16'(oldest.body.mem_write_data),
						16'(observed.mem_write_data));
					compare_field("accumulator", 16'(oldest.body.accumulator),
						16'(observed.accumulator));
					compare_field("flag_bits", 16'(oldest.body.flag_bits),
						16'(observed.flag_bits));
					compare_field("interrupts_enabled", 16'(oldest.body.interrupts_enabled),
						16'(observed.interrupts_enabled));
					compare_field("pair_hl", oldest.body.pair_hl, observed.pair_hl);
					compare_field("clock_count", 16'(oldest.body.clock_count),
						16'(observed.clock_count));
					compare_field("unknown_opcode", 16'(oldest.unknown), 16'(m_tuser));
					checked++;
				end
			end
			if (s_tvalid && s_tready) begin
				execute_opcode(s_tdata[7:0], s_tdata[15:8], predicted);
				outcome_queue.push_back(predicted);
			end
			pending = outcome_queue.size();
		end
	end

endmodule

// ===== tb/sv/sm83_load_add_execute_tb.sv =====
// Top of the SM83 load/add core testbench: clock, reset, request and result traffic, verdict.
`timescale 1ns / 1ps

module sm83_load_add_execute_tb;
	import sm83_pkg::*;

	localparam int RANDOM_COUNT   = 1600;
	localparam int FULL_RATE_FROM = 300;
	localparam int FULL_RATE_TO   = 500;
	localparam int DRAIN_AT       = 900;
	localparam int HOLD_AT_RESULT = 700;
	localparam int HOLD_CYCLES    = 300;
	localparam int IDLE_LIMIT     = 4000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic [15:0] s_tdata;   // func[7:0], mem_read_data[15:8]
	logic        m_tready;
	wire         s_tready;
	wire         m_tvalid;
	wire  [63:0] m_tdata;   // mem_write_enable[0], mem_write_address[16:1],
	                        // mem_write_data[24:17], accumulator[32:25],
	                        // flag_bits[36:33], interrupts_enabled[37],
	                        // pair_hl[53:38], clock_count[57:54], zero above
	wire         m_tuser;   // unknown_opcode[0]

	int error_count;
	int pending_count;
	int results_checked;
	int idle_cycles = 0;
	logic full_rate = 1'b0;

	// Directed requests as {mem_read_data, func}: control opcodes, (HL) forms with
	// extreme bytes, new H:L from memory, writes through HL, every ADD flag and
	// undefined opcodes around the implemented groups.
	logic [15:0] directed_requests [$] = '{
		{8'hFF, OP_NOP}, {8'hAA, OP_STOP}, {8'h55, OP_HALT},
		{8'h00, OP_EI}, {8'hFF, OP_DI}, {8'h12, OP_EI},
		{8'hFF, {GRP_LD, CODE_A, CODE_HL}}, {8'h01, {GRP_ALU, ALU_ADD, CODE_HL}},
		{8'h0F, {GRP_LD, CODE_B, CODE_HL}}, {8'h00, {GRP_LD, CODE_A, CODE_B}},
		{8'h00, {GRP_ALU, ALU_ADD, CODE_B}}, {8'h80, {GRP_LD, CODE_H, CODE_HL}},
		{8'h01, {GRP_LD, CODE_L, CODE_HL}}, {8'h00, {GRP_LD, CODE_HL, CODE_A}},
		{8'h00, {GRP_LD, CODE_HL, CODE_B}}, {8'h00, {GRP_LD, CODE_HL, CODE_L}},
		{8'h00, {GRP_LD, CODE_HL, CODE_H}}, {8'hF0, {GRP_ALU, ALU_ADD, CODE_A}},
		{8'h00, {GRP_ALU, ALU_ADD, CODE_L}}, {8'h00, {GRP_LD, CODE_A, CODE_A}},
		{8'h00, {GRP_LD, CODE_B, CODE_B}}, {8'h00, {GRP_LD, CODE_C, CODE_L}},
		{8'hFF, 8'h01}, {8'h00, 8'hFF}, {8'h3C, 8'h88}, {8'hC3, 8'hC6}
	};

	sm83_load_add_execute uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	sm83_load_add_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.error_count     (error_count),
		.pending_count   (pending_count),
		.results_checked (results_checked)
	);

	// 12 ns clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// End the run when neither side has moved anything for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("sm83_load_add_execute_tb: errors");
			$finish;
		end
	end

	// Result side: random stalls, none during the full-rate stretch, and one long hold-off.
	initial begin : result_sink
		int stall;
		int taken;
		taken = 0;
		m_tready = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (taken == HOLD_AT_RESULT)
				stall = HOLD_CYCLES;
			else if (full_rate)
				stall = 0;
			else
				stall = $urandom_range(0, 4);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(negedge clk); while (!m_tvalid);
			@(posedge clk);
			taken++;
		end
	end

	// Request side: reset, directed requests, then random ones.
	initial begin : request_source
		int total;
		int gap;
		int pick;
		logic [7:0] func;
		logic [7:0] mem_byte;
		total    = directed_requests.size() + RANDOM_COUNT;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		arst_n   = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < total; i++) begin
			if (i < directed_requests.size()) begin
				{mem_byte, func} = directed_requests[i];
			end else begin
				// Mostly implemented opcodes with random operands, some raw bytes.
				pick = $urandom_range(0, 99);
				if (pick < 55)
					func = {GRP_LD, 6'($urandom_range(0, 63))};
				else if (pick < 80)
					func = {GRP_ALU, ALU_ADD, 3'($urandom_range(0, 7))};
				else if (pick < 88) begin
					case ($urandom_range(0, 4))
						0:       func = OP_NOP;
						1:       func = OP_STOP;
						2:       func = OP_HALT;
						3:       func = OP_DI;
						default: func = OP_EI;
					endcase
				end else
					func = 8'($urandom_range(0, 255));
				mem_byte = 8'($urandom_range(0, 255));
			end

			// Let every result come back once, midway through the random part.
			if (i == directed_requests.size() + DRAIN_AT) begin
				s_tvalid <= 1'b0;
				do @(negedge clk); while (pending_count != 0);
				@(posedge clk);
			end

			full_rate = (i >= directed_requests.size() + FULL_RATE_FROM) &&
				(i < directed_requests.size() + FULL_RATE_TO);
			gap = full_rate ? 0 : $urandom_range(0, 4);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= {mem_byte, func};
			do @(negedge clk); while (!s_tready);
			@(posedge clk);
		end
		s_tvalid  <= 1'b0;
		full_rate = 1'b0;

		// Drain, then keep watching the core's output for anything stray.
		do @(negedge clk); while (pending_count != 0);
		repeat (4) @(posedge clk);

		$display("Sent %0d requests: %0d directed, then random loads, adds, %s",
			total, directed_requests.size(), "control and raw opcodes.");
		$display("Compared %0d results across random stalls, a full-rate stretch, %s",
			results_checked, "a long hold-off and a drain.");
		if (error_count == 0)
			$display("sm83_load_add_execute_tb: clean");
		else
			$display("sm83_load_add_execute_tb: errors");
		$finish;
	end

endmodule
